// ===== design/hsq_pkg.sv =====
// ----------------------------------------------------------------------------
// hsq_pkg: shared types and constants of the hit sensor sample qualifier
// Phase codes, operation codes, register indexes and the configuration and
// result structs used across the block.
// ----------------------------------------------------------------------------
package hsq_pkg;

  localparam int TIMER_W  = 14;
  localparam int SAMPLE_W = 10;
  localparam int SENS_W   = 4;
  localparam int PERIOD_W = 4;
  localparam int READ_W   = 16;
  localparam int INDEX_W  = 3;
  localparam int DATA_W   = 14;

  typedef enum logic [1:0] {
    PH_ARMED      = 2'd0,
    PH_SAMPLING   = 2'd1,
    PH_SEPARATION = 2'd2
  } phase_t;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [INDEX_W-1:0] REG_ENABLE         = 3'd0;
  localparam logic [INDEX_W-1:0] REG_BURST_MODE     = 3'd1;
  localparam logic [INDEX_W-1:0] REG_SENSITIVITY    = 3'd2;
  localparam logic [INDEX_W-1:0] REG_SEPARATION_MS  = 3'd3;
  localparam logic [INDEX_W-1:0] REG_WINDOW_SAMPLES = 3'd4;
  localparam logic [INDEX_W-1:0] REG_PERIOD_MS      = 3'd5;
  localparam logic [INDEX_W-1:0] REG_ACTIVE_LEVEL   = 3'd6;

  localparam logic                MODE_SINGLE            = 1'b0;
  localparam logic [SENS_W-1:0]   SENSITIVITY_DEFAULT    = 4'd1;
  localparam logic [TIMER_W-1:0]  SEPARATION_MS_DEFAULT  = 14'd250;
  localparam logic [SAMPLE_W-1:0] WINDOW_SAMPLES_DEFAULT = 10'd50;
  localparam logic [PERIOD_W-1:0] PERIOD_MS_DEFAULT      = 4'd2;

  typedef struct packed {
    logic                enable;
    logic                burst_mode;
    logic [SENS_W-1:0]   sensitivity;
    logic [TIMER_W-1:0]  separation_ms;
    logic [SAMPLE_W-1:0] window_samples;
    logic [PERIOD_W-1:0] period_ms;
    logic                active_level;
  } hsq_cfg_t;

  typedef struct packed {
    logic              hit_event;
    logic [READ_W-1:0] hits_read;
    phase_t            phase;
  } hsq_result_t;

endpackage

// ===== design/hit_sensor_sample_qualifier_unit.sv =====
// ----------------------------------------------------------------------------
// hit_sensor_sample_qualifier_unit: qualifies sensor hits on millisecond ticks
// Path: input register, then result register fed by one pass of qualifier logic.
// Throughput: one item per cycle while the downstream side does not stall; the
// input register can hold one item while a result waits for the downstream side.
// Reset: synchronous rst clears handshake state and qualifier state, and sets
// the settings to their defaults.
// ----------------------------------------------------------------------------
module hit_sensor_sample_qualifier_unit #(
  parameter int HIT_COUNT_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [hsq_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [hsq_pkg::DATA_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         operation,
  input  logic                         sensor_level,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit_event,
  output logic [hsq_pkg::READ_W-1:0]   hits_read,
  output logic [1:0]                   phase
);
  import hsq_pkg::*;

  hsq_cfg_t    cfg;
  hsq_result_t result;
  logic        clear;
  logic        in_full;
  logic        in_op;
  logic        in_level;
  logic        advance;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  hsq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .clear     (clear)
  );

  hsq_core #(
    .HIT_COUNT_WIDTH (HIT_COUNT_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .clear        (clear),
    .step         (advance),
    .operation    (in_op),
    .sensor_level (in_level),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_op    <= operation;
      in_level <= sensor_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit_event <= result.hit_event;
      hits_read <= result.hits_read;
      phase     <= result.phase;
    end
  end

endmodule

// ===== design/hsq_cfg.sv =====
// ----------------------------------------------------------------------------
// hsq_cfg: configuration registers
// Holds the seven settings; a write to enable also pulses a clear of the
// qualifier activity. Other settings are locked while enabled.
// ----------------------------------------------------------------------------
module hsq_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [hsq_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [hsq_pkg::DATA_W-1:0]   cfg_data,
  output hsq_pkg::hsq_cfg_t            cfg,
  output logic                         clear
);
  import hsq_pkg::*;

  assign clear = cfg_write && (cfg_index == REG_ENABLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable         <= 1'b0;
      cfg.burst_mode     <= MODE_SINGLE;
      cfg.sensitivity    <= SENSITIVITY_DEFAULT;
      cfg.separation_ms  <= SEPARATION_MS_DEFAULT;
      cfg.window_samples <= WINDOW_SAMPLES_DEFAULT;
      cfg.period_ms      <= PERIOD_MS_DEFAULT;
      cfg.active_level   <= 1'b1;
    end else if (cfg_write) begin
      if (cfg_index == REG_ENABLE) begin
        cfg.enable <= cfg_data[0];
      end else if (!cfg.enable) begin
        case (cfg_index)
          REG_BURST_MODE:     cfg.burst_mode     <= cfg_data[0];
          REG_SENSITIVITY:    cfg.sensitivity    <= cfg_data[SENS_W-1:0];
          REG_SEPARATION_MS:  cfg.separation_ms  <= cfg_data[TIMER_W-1:0];
          REG_WINDOW_SAMPLES: cfg.window_samples <= cfg_data[SAMPLE_W-1:0];
          REG_PERIOD_MS:      cfg.period_ms      <= cfg_data[PERIOD_W-1:0];
          REG_ACTIVE_LEVEL:   cfg.active_level   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== design/hsq_core.sv =====
// ----------------------------------------------------------------------------
// hsq_core: qualifier state and single-pass update
// Holds phase, timer, sample counts, hit total and last level, and computes
// the next state and the result of one item in one pass.
// ----------------------------------------------------------------------------
module hsq_core #(
  parameter int HIT_COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  hsq_pkg::hsq_cfg_t     cfg,
  input  logic                  clear,
  input  logic                  step,
  input  logic                  operation,
  input  logic                  sensor_level,
  output hsq_pkg::hsq_result_t  result
);
  import hsq_pkg::*;

  phase_t                     phase_reg, phase_reg_next;
  logic [TIMER_W-1:0]         tick_timer, tick_timer_next;
  logic [SAMPLE_W-1:0]        samples_left, samples_left_next;
  logic [SAMPLE_W-1:0]        active_samples, active_samples_next;
  logic [HIT_COUNT_WIDTH-1:0] hit_total, hit_total_next;
  logic                       last_level, last_level_next;

  logic [READ_W-1:0]   hits_sat;
  logic [TIMER_W-1:0]  period_load, separation_load, timer_dec;
  logic [SAMPLE_W-1:0] window_load, samples_dec, active_inc;
  logic                is_active, was_active;

  generate
    if (HIT_COUNT_WIDTH > READ_W) begin : g_sat
      assign hits_sat = (|hit_total[HIT_COUNT_WIDTH-1:READ_W]) ? '1
                                                               : hit_total[READ_W-1:0];
    end else begin : g_ext
      assign hits_sat = READ_W'(hit_total);
    end
  endgenerate

  assign period_load     = (cfg.period_ms == '0) ? TIMER_W'(1) : TIMER_W'(cfg.period_ms);
  assign separation_load = (cfg.separation_ms == '0) ? TIMER_W'(1) : cfg.separation_ms;
  assign window_load     = (cfg.window_samples == '0) ? SAMPLE_W'(1) : cfg.window_samples;
  assign timer_dec       = (tick_timer != '0) ? tick_timer - TIMER_W'(1) : '0;
  assign is_active       = (sensor_level == cfg.active_level);
  assign was_active      = (last_level == cfg.active_level);
  assign active_inc      = is_active ? active_samples + SAMPLE_W'(1) : active_samples;
  assign samples_dec     = (samples_left != '0) ? samples_left - SAMPLE_W'(1) : '0;

  always_comb begin
    phase_reg_next      = phase_reg;
    tick_timer_next     = tick_timer;
    samples_left_next   = samples_left;
    active_samples_next = active_samples;
    hit_total_next      = hit_total;
    last_level_next     = last_level;
    result.hit_event    = 1'b0;
    result.hits_read    = '0;
    if (operation == OP_READ) begin
      if (cfg.enable) begin
        result.hits_read = hits_sat;
        hit_total_next   = '0;
      end
    end else if (!cfg.enable) begin
      phase_reg_next      = PH_ARMED;
      tick_timer_next     = '0;
      samples_left_next   = '0;
      active_samples_next = '0;
      hit_total_next      = '0;
      last_level_next     = sensor_level;
    end else begin
      last_level_next = sensor_level;
      case (phase_reg)
        PH_ARMED: begin
          if (is_active && !was_active) begin
            phase_reg_next      = PH_SAMPLING;
            samples_left_next   = window_load;
            active_samples_next = '0;
            tick_timer_next     = period_load;
          end
        end
        PH_SAMPLING: begin
          tick_timer_next = timer_dec;
          if (timer_dec == '0) begin
            active_samples_next = active_inc;
            samples_left_next   = samples_dec;
            if (samples_dec == '0) begin
              if (active_inc >= SAMPLE_W'(cfg.sensitivity)) begin
                if (hit_total != '1) begin
                  hit_total_next = hit_total + HIT_COUNT_WIDTH'(1);
                end
                result.hit_event = 1'b1;
              end
              if (cfg.burst_mode == MODE_SINGLE) begin
                phase_reg_next  = PH_ARMED;
                tick_timer_next = '0;
              end else begin
                phase_reg_next  = PH_SEPARATION;
                tick_timer_next = separation_load;
              end
            end else begin
              tick_timer_next = period_load;
            end
          end
        end
        default: begin
          tick_timer_next = timer_dec;
          if (timer_dec == '0) begin
            phase_reg_next = PH_ARMED;
          end
        end
      endcase
    end
    result.phase = phase_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg      <= PH_ARMED;
      tick_timer     <= '0;
      samples_left   <= '0;
      active_samples <= '0;
      hit_total      <= '0;
      last_level     <= 1'b0;
    end else if (clear) begin
      phase_reg      <= PH_ARMED;
      tick_timer     <= '0;
      samples_left   <= '0;
      active_samples <= '0;
      hit_total      <= '0;
    end else if (step) begin
      phase_reg      <= phase_reg_next;
      tick_timer     <= tick_timer_next;
      samples_left   <= samples_left_next;
      active_samples <= active_samples_next;
      hit_total      <= hit_total_next;
      last_level     <= last_level_next;
    end
  end

endmodule

// ===== test/hit_sensor_sample_qualifier_unit_test.sv =====
// ----------------------------------------------------------------------------
// hit_sensor_sample_qualifier_unit_test: self-checking bench for the qualifier
// Drives ticks and reads through the valid/stall channel under several
// settings and idling patterns, predicts every result item in a scoreboard
// that tracks windows, burst waits and the saturating hit count, and checks
// each result field as it leaves the block.
// ----------------------------------------------------------------------------
module hit_sensor_sample_qualifier_unit_test;
  import hsq_pkg::*;

  localparam int HIT_COUNT_WIDTH = 16;
  localparam int CYCLE_LIMIT     = 2000000;
  localparam int DRAIN_CYCLES    = 6;
  localparam int HOLD_CYCLES     = 300;
  localparam logic [INDEX_W-1:0] REG_UNUSED = 3'd7;

  class hit_qualifier_scoreboard;
    hsq_cfg_t                   cfg;
    phase_t                     ph;
    logic [TIMER_W-1:0]         timer;
    logic [SAMPLE_W-1:0]        samples_left;
    logic [SAMPLE_W-1:0]        active_cnt;
    logic [HIT_COUNT_WIDTH-1:0] hit_total;
    logic                       last_level;
    hsq_result_t                due_results[$];
    int                         errors;

    function new();
      cfg.enable         = 1'b0;
      cfg.burst_mode     = MODE_SINGLE;
      cfg.sensitivity    = SENSITIVITY_DEFAULT;
      cfg.separation_ms  = SEPARATION_MS_DEFAULT;
      cfg.window_samples = WINDOW_SAMPLES_DEFAULT;
      cfg.period_ms      = PERIOD_MS_DEFAULT;
      cfg.active_level   = 1'b1;
      clear_activity();
      last_level = 1'b0;
      errors     = 0;
    endfunction

    function void clear_activity();
      ph           = PH_ARMED;
      timer        = '0;
      samples_left = '0;
      active_cnt   = '0;
      hit_total    = '0;
    endfunction

    function logic [TIMER_W-1:0] at_least_one(logic [TIMER_W-1:0] v);
      return (v == '0) ? TIMER_W'(1) : v;
    endfunction

    function void write_setting(logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
      if (idx == REG_ENABLE) begin
        cfg.enable = data[0];
        clear_activity();
      end else if (!cfg.enable) begin
        case (idx)
          REG_BURST_MODE:     cfg.burst_mode     = data[0];
          REG_SENSITIVITY:    cfg.sensitivity    = data[SENS_W-1:0];
          REG_SEPARATION_MS:  cfg.separation_ms  = data[TIMER_W-1:0];
          REG_WINDOW_SAMPLES: cfg.window_samples = data[SAMPLE_W-1:0];
          REG_PERIOD_MS:      cfg.period_ms      = data[PERIOD_W-1:0];
          REG_ACTIVE_LEVEL:   cfg.active_level   = data[0];
          default: ;
        endcase
      end
    endfunction

    function void note_item(logic op, logic lvl);
      hsq_result_t res;
      logic        is_act;
      logic        was_act;
      res = '0;
      if (op == OP_READ) begin
        if (cfg.enable) begin
          res.hits_read = READ_W'(hit_total);
          hit_total = '0;
        end
      end else if (!cfg.enable) begin
        clear_activity();
        last_level = lvl;
      end else begin
        is_act  = (lvl == cfg.active_level);
        was_act = (last_level == cfg.active_level);
        case (ph)
          PH_ARMED: begin
            if (is_act && !was_act) begin
              ph           = PH_SAMPLING;
              samples_left = SAMPLE_W'(at_least_one(TIMER_W'(cfg.window_samples)));
              active_cnt   = '0;
              timer        = at_least_one(TIMER_W'(cfg.period_ms));
            end
          end
          PH_SAMPLING: begin
            if (timer != '0) timer--;
            if (timer == '0) begin
              if (is_act) active_cnt++;
              if (samples_left != '0) samples_left--;
              if (samples_left == '0) begin
                if (active_cnt >= cfg.sensitivity) begin
                  if (hit_total != '1) hit_total++;
                  res.hit_event = 1'b1;
                end
                if (cfg.burst_mode == MODE_SINGLE) begin
                  ph    = PH_ARMED;
                  timer = '0;
                end else begin
                  ph    = PH_SEPARATION;
                  timer = at_least_one(cfg.separation_ms);
                end
              end else begin
                timer = at_least_one(TIMER_W'(cfg.period_ms));
              end
            end
          end
          default: begin
            if (timer != '0) timer--;
            if (timer == '0) ph = PH_ARMED;
          end
        endcase
        last_level = lvl;
      end
      res.phase = ph;
      due_results.push_back(res);
    endfunction

    function void mismatch(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(logic hit, logic [READ_W-1:0] rd, logic [1:0] ph_out);
      hsq_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result with no item outstanding: hit_event %0d hits_read %0d phase %0d",
                 $time, hit, rd, ph_out);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (hit !== want.hit_event) mismatch("hit_event", 32'(want.hit_event), 32'(hit));
      if (rd !== want.hits_read) mismatch("hits_read", 32'(want.hits_read), 32'(rd));
      if (ph_out !== want.phase) mismatch("phase", 32'(want.phase), 32'(ph_out));
    endfunction
  endclass

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                cfg_write    = 1'b0;
  logic [INDEX_W-1:0]  cfg_index    = REG_ENABLE;
  logic [DATA_W-1:0]   cfg_data     = '0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic                operation    = OP_TICK;
  logic                sensor_level = 1'b0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic                hit_event;
  logic [READ_W-1:0]   hits_read;
  logic [1:0]          phase;

  int   src_idle_pct   = 0;
  int   sink_stall_pct = 0;
  int   hold_ask       = 0;
  int   hold_seen      = 0;
  int   hold_left      = 0;
  int   cycle_count    = 0;
  logic pin_level      = 1'b0;

  hit_qualifier_scoreboard qual = new();

  hit_sensor_sample_qualifier_unit #(
    .HIT_COUNT_WIDTH(HIT_COUNT_WIDTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .sensor_level (sensor_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit_event    (hit_event),
    .hits_read    (hits_read),
    .phase        (phase)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) qual.note_item(operation, sensor_level);
      if (out_valid && !out_stall) qual.check_result(hit_event, hits_read, phase);
    end
  end

  task automatic set_idling(int mode);
    case (mode)
      0: begin src_idle_pct <= 0;  sink_stall_pct <= 0;  end
      1: begin src_idle_pct <= 55; sink_stall_pct <= 0;  end
      2: begin src_idle_pct <= 0;  sink_stall_pct <= 55; end
      default: begin src_idle_pct <= 25; sink_stall_pct <= 25; end
    endcase
  endtask

  task automatic send_item(logic op, logic lvl);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    sensor_level <= lvl;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (qual.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [INDEX_W-1:0] idx, int unsigned data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= DATA_W'(data);
    @(posedge clk);
    qual.write_setting(idx, DATA_W'(data));
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(int unsigned burst, int unsigned sens, int unsigned sep,
                                int unsigned win, int unsigned per, int unsigned act);
    drain();
    write_reg(REG_ENABLE, 0);
    write_reg(REG_BURST_MODE, burst);
    write_reg(REG_SENSITIVITY, sens);
    write_reg(REG_SEPARATION_MS, sep);
    write_reg(REG_WINDOW_SAMPLES, win);
    write_reg(REG_PERIOD_MS, per);
    write_reg(REG_ACTIVE_LEVEL, act);
    write_reg(REG_ENABLE, 1);
    // enabled: this write must be dropped
    write_reg(INDEX_W'($urandom_range(REG_UNUSED, REG_BURST_MODE)), $urandom);
  endtask

  task automatic send_run(int count, int flip_pct, int read_pct);
    logic op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(99) < read_pct) ? OP_READ : OP_TICK;
      if (op == OP_TICK && $urandom_range(99) < flip_pct) pin_level = ~pin_level;
      send_item(op, (op == OP_READ) ? logic'($urandom_range(1)) : pin_level);
    end
  endtask

  initial begin
    int unsigned win;
    int unsigned sens;
    int          flip;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_idling(3);

    // disabled after reset
    send_item(OP_READ, 1'b1);
    send_item(OP_TICK, 1'b1);
    send_item(OP_TICK, 1'b0);

    // single mode, window of three, needs two active samples
    apply_settings(MODE_SINGLE, 2, 100, 3, 1, 1);
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b1);
    send_item(OP_TICK, 1'b1);
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b1);
    send_item(OP_READ, 1'b0);
    send_item(OP_READ, 1'b1);

    // burst mode, zero sizes act as one, zero sensitivity, active low
    apply_settings(1, 0, 0, 0, 0, 0);
    send_item(OP_TICK, 1'b1);
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b1);
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b1);
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b1);
    send_item(OP_READ, 1'b0);

    // longest period, highest sensitivity, long separation
    set_idling(0);
    apply_settings(1, 15, 100, 16, 15, 1);
    send_item(OP_TICK, 1'b0);
    repeat (16 * 15 + 100 + 8) send_item(OP_TICK, $urandom_range(19) != 0);
    send_item(OP_READ, 1'b0);

    for (int p = 0; p < 10; p++) begin
      set_idling(p % 4);
      if (p == 4) begin
        drain();
        write_reg(REG_ENABLE, 0);
        write_reg(REG_UNUSED, $urandom);
        send_run(140, 30, 15);
      end else begin
        win  = $urandom_range(0, 6);
        sens = ($urandom_range(3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, win + 1);
        apply_settings($urandom_range(1), sens, $urandom_range(0, 12), win,
                       $urandom_range(0, 3), $urandom_range(1));
        flip = $urandom_range(5, 50);
        if (p == 6) begin
          hold_ask <= hold_ask + 1;
          send_run(140, flip, 10);
        end else if (p == 3) begin
          send_run(70, flip, 10);
          drain();
          send_run(70, flip, 10);
        end else begin
          send_run(140, flip, 10);
        end
      end
    end

    drain();
    if (qual.errors == 0 && qual.due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/hsq_pkg.sv
design/hsq_cfg.sv
design/hsq_core.sv
design/hit_sensor_sample_qualifier_unit.sv
test/hit_sensor_sample_qualifier_unit_test.sv
